>>> rtl/core/mreb_pkg.sv
// Shared types, constants and SHA-256 helpers for the measurement register bank.
`timescale 1ns / 1ps
package mreb_pkg;

    localparam int NUM_REGISTERS_DEF = 4;
    localparam int KIND_W            = 2;
    localparam int FIELD_W           = 32;
    localparam int DIG_W             = 64;
    localparam int SLOT_W            = 2;
    localparam int REG_W             = 256;
    localparam int ROUND_W           = 6;

    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_CLEAR = 2'd0;
    localparam t_kind KIND_EVENT = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;
    localparam t_kind KIND_RSVD  = 2'd3;

    localparam logic [FIELD_W-1:0] NO_ACTION_TYPE = 32'h0000_0003;
    localparam logic [FIELD_W-1:0] LOG_END_MARK   = 32'hFFFF_FFFF;

    // Padding words of the second block: one bit after the message, length 512.
    localparam logic [31:0] PAD_FIRST = 32'h8000_0000;
    localparam logic [31:0] PAD_LEN   = 32'd512;

    // Controller to datapath
    typedef struct packed {
        logic cap;
        logic start;
        logic round;
        logic fin1;
        logic fin2;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic do_ext;
        logic round_last;
    } t_stat;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/core/mreb_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface mreb_in_if;
    logic                          valid;
    logic                          ready;
    logic [mreb_pkg::KIND_W-1:0]   kind;
    logic [mreb_pkg::FIELD_W-1:0]  register_number;
    logic [mreb_pkg::FIELD_W-1:0]  rec_type;
    logic [mreb_pkg::FIELD_W-1:0]  num_digests;
    logic [mreb_pkg::DIG_W-1:0]    digest_word0;
    logic [mreb_pkg::DIG_W-1:0]    digest_word1;
    logic [mreb_pkg::DIG_W-1:0]    digest_word2;
    logic [mreb_pkg::DIG_W-1:0]    digest_word3;

    modport source (output valid, kind, register_number, rec_type, num_digests,
                    digest_word0, digest_word1, digest_word2, digest_word3,
                    input ready);
    modport sink   (input valid, kind, register_number, rec_type, num_digests,
                    digest_word0, digest_word1, digest_word2, digest_word3,
                    output ready);
endinterface

interface mreb_out_if;
    logic                          valid;
    logic                          ready;
    logic [mreb_pkg::SLOT_W-1:0]   slot_index;
    logic                          extended;
    logic [mreb_pkg::DIG_W-1:0]    value_word0;
    logic [mreb_pkg::DIG_W-1:0]    value_word1;
    logic [mreb_pkg::DIG_W-1:0]    value_word2;
    logic [mreb_pkg::DIG_W-1:0]    value_word3;

    modport source (output valid, slot_index, extended,
                    value_word0, value_word1, value_word2, value_word3,
                    input ready);
    modport sink   (input valid, slot_index, extended,
                    value_word0, value_word1, value_word2, value_word3,
                    output ready);
endinterface

>>> rtl/core/measurement_register_extend_bank_top.sv
// Top level of the measurement register bank with SHA-256 extend.
//
// Usage:
//   i_in  : input words (clear all, event record, read register), valid/ready.
//   o_out : one result word per input word, valid/ready, held in a register.
//   A word is accepted only while the block is idle; i_in.ready is low from
//   the cycle after acceptance until the result has been loaded into o_out.
// Sequence:
//   Clear, read, or a record that does not extend: decide, then load the
//   result into o_out.
//   Extending record: decide, 64 rounds, fold, 64 rounds, fold, load. The
//   single SHA-256 round unit, one round per cycle, runs both sets of
//   rounds.
// Reset: i_rst_n synchronous active low; all registers read as zero,
//   o_out.valid drops, the block is idle.
// Stall: a finished result sits in the o_out register. The next word may be
//   accepted meanwhile; its result waits in the controller until o_out frees.
`timescale 1ns / 1ps
module measurement_register_extend_bank_top #(
    parameter int NUM_REGISTERS = mreb_pkg::NUM_REGISTERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mreb_in_if.sink     i_in,
    mreb_out_if.source  o_out
);
    import mreb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mreb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mreb_dp #(
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_kind            (i_in.kind),
        .i_register_number (i_in.register_number),
        .i_rec_type        (i_in.rec_type),
        .i_num_digests     (i_in.num_digests),
        .i_digest_word0    (i_in.digest_word0),
        .i_digest_word1    (i_in.digest_word1),
        .i_digest_word2    (i_in.digest_word2),
        .i_digest_word3    (i_in.digest_word3),
        .o_slot_index      (o_out.slot_index),
        .o_extended        (o_out.extended),
        .o_value_word0     (o_out.value_word0),
        .o_value_word1     (o_out.value_word1),
        .o_value_word2     (o_out.value_word2),
        .o_value_word3     (o_out.value_word3)
    );

endmodule

>>> rtl/core/mreb_ctrl.sv
// Sequencing state machine: accept, two compression passes when extending, result hand-off.
`timescale 1ns / 1ps
module mreb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  mreb_pkg::t_stat  i_stat,
    output mreb_pkg::t_cmd   o_cmd
);
    import mreb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ROUND1,
        ST_FIN1,
        ST_ROUND2,
        ST_FIN2,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_emit_ok;

    assign w_emit_ok   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_stat.do_ext) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_ROUND1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_ROUND1: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_last) begin
                    n_state = ST_FIN1;
                end
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = ST_ROUND2;
            end
            ST_ROUND2: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_last) begin
                    n_state = ST_FIN2;
                end
            end
            ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/mreb_dp.sv
// Register bank, SHA-256 round datapath and result register.
`timescale 1ns / 1ps
module mreb_dp #(
    parameter int NUM_REGISTERS = mreb_pkg::NUM_REGISTERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mreb_pkg::t_cmd                i_cmd,
    output mreb_pkg::t_stat               o_stat,
    input  logic [mreb_pkg::KIND_W-1:0]   i_kind,
    input  logic [mreb_pkg::FIELD_W-1:0]  i_register_number,
    input  logic [mreb_pkg::FIELD_W-1:0]  i_rec_type,
    input  logic [mreb_pkg::FIELD_W-1:0]  i_num_digests,
    input  logic [mreb_pkg::DIG_W-1:0]    i_digest_word0,
    input  logic [mreb_pkg::DIG_W-1:0]    i_digest_word1,
    input  logic [mreb_pkg::DIG_W-1:0]    i_digest_word2,
    input  logic [mreb_pkg::DIG_W-1:0]    i_digest_word3,
    output logic [mreb_pkg::SLOT_W-1:0]   o_slot_index,
    output logic                          o_extended,
    output logic [mreb_pkg::DIG_W-1:0]    o_value_word0,
    output logic [mreb_pkg::DIG_W-1:0]    o_value_word1,
    output logic [mreb_pkg::DIG_W-1:0]    o_value_word2,
    output logic [mreb_pkg::DIG_W-1:0]    o_value_word3
);
    import mreb_pkg::*;

    localparam int IDX_W = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;

    // captured item
    t_kind               r_kind;
    logic [IDX_W-1:0]    r_idx;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_in_range;
    logic                r_do_ext;
    logic [DIG_W-1:0]    r_dig [4];

    logic [REG_W-1:0]    r_bank [NUM_REGISTERS];

    logic [31:0]         r_h [8];
    logic [31:0]         r_v [8];
    logic [31:0]         r_w [16];
    logic [ROUND_W-1:0]  r_cnt;

    logic [REG_W-1:0]    r_val;
    logic [SLOT_W-1:0]   r_slot_o;
    logic                r_ext_o;

    logic [FIELD_W-1:0]  w_idx32;
    logic                w_in_range;
    logic                w_end_mark;
    logic                w_do_ext;
    logic [31:0]         w_t1;
    logic [31:0]         w_t2;
    logic [31:0]         w_wnew;
    logic [31:0]         w_hn [8];
    logic [REG_W-1:0]    w_cur;
    logic [REG_W-1:0]    w_hcat;
    logic                w_readable;

    // index = number - 1, floored at zero
    assign w_idx32    = (i_register_number == '0) ? '0 : i_register_number - 32'd1;
    assign w_in_range = (w_idx32 < 32'(NUM_REGISTERS));
    assign w_end_mark = (i_register_number == LOG_END_MARK) && (i_rec_type == LOG_END_MARK);
    assign w_do_ext   = (i_kind == KIND_EVENT) && w_in_range && !w_end_mark
                        && (i_rec_type != NO_ACTION_TYPE) && (i_num_digests != '0);

    assign o_stat.do_ext     = r_do_ext;
    assign o_stat.round_last = (r_cnt == {ROUND_W{1'b1}});

    assign w_cur      = r_bank[r_idx];
    assign w_readable = r_in_range && ((r_kind == KIND_EVENT) || (r_kind == KIND_READ));

    always_comb begin
        w_t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
               + SHA_K[r_cnt] + r_w[0];
        w_t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_wnew = sml_sig1(r_w[14]) + r_w[9] + sml_sig0(r_w[1]) + r_w[0];
        for (int i = 0; i < 8; i++) begin
            w_hn[i] = r_h[i] + r_v[i];
        end
        for (int i = 0; i < 8; i++) begin
            w_hcat[REG_W-1-32*i -: 32] = w_hn[i];
        end
    end

    // capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind     <= i_kind;
            r_idx      <= w_idx32[IDX_W-1:0];
            r_slot     <= w_in_range ? w_idx32[SLOT_W-1:0] : '0;
            r_in_range <= w_in_range;
            r_dig[0]   <= i_digest_word0;
            r_dig[1]   <= i_digest_word1;
            r_dig[2]   <= i_digest_word2;
            r_dig[3]   <= i_digest_word3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_ext <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_do_ext <= w_do_ext;
            end
            if (i_cmd.start || i_cmd.fin1) begin
                r_cnt <= '0;
            end else if (i_cmd.round) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // compression state
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i]     <= SHA_INIT[i];
                r_v[i]     <= SHA_INIT[i];
                r_w[i]     <= w_cur[REG_W-1-32*i -: 32];
            end
            for (int k = 0; k < 4; k++) begin
                r_w[8+2*k] <= r_dig[k][63:32];
                r_w[9+2*k] <= r_dig[k][31:0];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wnew;
        end else if (i_cmd.fin1) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= w_hn[i];
                r_v[i] <= w_hn[i];
            end
            for (int i = 1; i < 15; i++) begin
                r_w[i] <= '0;
            end
            r_w[0]  <= PAD_FIRST;
            r_w[15] <= PAD_LEN;
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGISTERS; r++) begin
                r_bank[r] <= '0;
            end
        end else if (i_cmd.emit && (r_kind == KIND_CLEAR)) begin
            for (int r = 0; r < NUM_REGISTERS; r++) begin
                r_bank[r] <= '0;
            end
        end else if (i_cmd.fin2) begin
            r_bank[r_idx] <= w_hcat;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_val    <= w_readable ? w_cur : '0;
            r_slot_o <= w_readable ? r_slot : '0;
            r_ext_o  <= r_do_ext;
        end
    end

    assign o_slot_index  = r_slot_o;
    assign o_extended    = r_ext_o;
    assign o_value_word0 = r_val[255:192];
    assign o_value_word1 = r_val[191:128];
    assign o_value_word2 = r_val[127:64];
    assign o_value_word3 = r_val[63:0];

endmodule

>>> rtl/core/mreb_chk.sv
// Port-level assertions for the measurement register bank, bound to the top.
`timescale 1ns / 1ps
module mreb_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_extended
);

    // one word in flight: no acceptance right after one
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    a_ext_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 !(i_out_valid && i_out_extended && $rose(i_out_valid)))
        else $error("extended result appeared too early");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind measurement_register_extend_bank_top mreb_chk u_mreb_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_extended (o_out.extended)
);

>>> tb/mreb_result_checker.sv
// Watches both channels, predicts each result word with a SHA-256 extend model and compares.
`timescale 1ns / 1ps
module mreb_result_checker #(
    parameter int NUM_REGISTERS = mreb_pkg::NUM_REGISTERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mreb_in_if   i_mon_in,
    mreb_out_if  i_mon_out,
    output int   o_fail_count,
    output int   o_pending
);
    import mreb_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              ext;
        logic [REG_W-1:0]  value;
    } t_result;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [255:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [REG_W-1:0] bank [NUM_REGISTERS];
    t_result          expected_q [$];
    int               fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] compress(input logic [255:0] hin, input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        logic [255:0] res;
        for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = hin;
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            res[255-32*i -: 32] = hin[255-32*i -: 32] + ((i == 0) ? a : (i == 1) ? b :
                (i == 2) ? c : (i == 3) ? d : (i == 4) ? e : (i == 5) ? f : (i == 6) ? g : h);
        return res;
    endfunction

    // new = SHA-256(old || digest); second block is pure padding, length 512.
    function automatic logic [255:0] chain_digest(input logic [255:0] old, input logic [255:0] dig);
        logic [255:0] st;
        st = compress(HASH_IV, {old, dig});
        return compress(st, {32'h8000_0000, 448'b0, 32'd512});
    endfunction

    function automatic t_result predict_step(input t_kind kind, input logic [31:0] num,
                                             input logic [31:0] etype, input logic [31:0] cnt,
                                             input logic [255:0] dig);
        t_result r;
        logic [31:0] idx;
        r = '0;
        idx = (num == 0) ? 32'd0 : num - 32'd1;
        if (kind == KIND_CLEAR) begin
            for (int i = 0; i < NUM_REGISTERS; i++) bank[i] = '0;
            return r;
        end
        if (kind != KIND_EVENT && kind != KIND_READ) return r;
        if (idx >= NUM_REGISTERS) return r;
        if (kind == KIND_EVENT && !(num == LOG_END_MARK && etype == LOG_END_MARK)
            && etype != NO_ACTION_TYPE && cnt != 0) begin
            bank[idx] = chain_digest(bank[idx], dig);
            r.ext = 1'b1;
        end
        r.slot  = idx[SLOT_W-1:0];
        r.value = bank[idx];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r, act_r;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGISTERS; i++) bank[i] = '0;
            expected_q.delete();
        end else begin
            if (i_mon_in.valid && i_mon_in.ready)
                expected_q.push_back(predict_step(i_mon_in.kind, i_mon_in.register_number,
                    i_mon_in.rec_type, i_mon_in.num_digests,
                    {i_mon_in.digest_word0, i_mon_in.digest_word1,
                     i_mon_in.digest_word2, i_mon_in.digest_word3}));
            if (i_mon_out.valid && i_mon_out.ready) begin
                act_r = {i_mon_out.slot_index, i_mon_out.extended, i_mon_out.value_word0,
                         i_mon_out.value_word1, i_mon_out.value_word2, i_mon_out.value_word3};
                if (expected_q.size() == 0) begin
                    $display("%t: unexpected result word slot=%0d ext=%0b value=%h",
                             $time, act_r.slot, act_r.ext, act_r.value);
                    fails++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.slot !== act_r.slot) begin
                        $display("%t: slot_index exp %0d got %0d", $time, exp_r.slot, act_r.slot);
                        fails++;
                    end
                    if (exp_r.ext !== act_r.ext) begin
                        $display("%t: extended exp %0b got %0b", $time, exp_r.ext, act_r.ext);
                        fails++;
                    end
                    for (int k = 0; k < 4; k++)
                        if (exp_r.value[255-64*k -: 64] !== act_r.value[255-64*k -: 64]) begin
                            $display("%t: value_word%0d exp %h got %h", $time, k,
                                     exp_r.value[255-64*k -: 64], act_r.value[255-64*k -: 64]);
                            fails++;
                        end
                end
            end
        end
    end

endmodule

>>> tb/measurement_register_extend_bank_top_tb.sv
// Stimulus, idling phases, watchdog and verdict for the measurement register bank.
`timescale 1ns / 1ps
module measurement_register_extend_bank_top_tb;
    import mreb_pkg::*;

    // Receiver stalls are short geometric runs.
    // Any window this long with no word moving on either side means a hang.
    localparam int HANG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 1250;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sender_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    mreb_in_if  in_ch ();
    mreb_out_if out_ch ();

    measurement_register_extend_bank_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mreb_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mon_in     (in_ch),
        .i_mon_out    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Result side: ready drops at random per the current stall rate.
    always @(posedge i_clk) begin
        out_ch.ready <= !i_rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: counts cycles with no word accepted on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Presents one input word and returns at the edge where it is taken.
    // Ready is looked at on the falling edge, clear of the block's own updates.
    task automatic send_word(input t_kind kind, input logic [31:0] num, input logic [31:0] etype,
                             input logic [31:0] cnt, input logic [255:0] dig);
        logic took;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= kind;
        in_ch.register_number <= num;
        in_ch.rec_type        <= etype;
        in_ch.num_digests     <= cnt;
        {in_ch.digest_word0, in_ch.digest_word1, in_ch.digest_word2, in_ch.digest_word3} <= dig;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    function automatic logic [255:0] rand_digest();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_field();
        return {$urandom};
    endfunction

    // Random word: mostly well-formed records aimed at live registers,
    // with reads, clears, the unused kind and wild numbers mixed in.
    task automatic send_random_word();
        int          pick;
        t_kind       kind;
        logic [31:0] num, etype, cnt;
        pick = $urandom_range(99);
        if (pick < 70)      kind = KIND_EVENT;
        else if (pick < 90) kind = KIND_READ;
        else if (pick < 96) kind = KIND_CLEAR;
        else                kind = KIND_RSVD;
        pick = $urandom_range(99);
        if (pick < 85)      num = $urandom_range(5);
        else if (pick < 90) num = LOG_END_MARK;
        else                num = rand_field();
        pick = $urandom_range(99);
        if (pick < 10)      etype = NO_ACTION_TYPE;
        else if (pick < 15) etype = LOG_END_MARK;
        else if (pick < 55) etype = $urandom_range(15);
        else                etype = rand_field();
        pick = $urandom_range(99);
        if (pick < 10)      cnt = 0;
        else if (pick < 60) cnt = 1;
        else                cnt = rand_field();
        send_word(kind, num, etype, cnt, rand_digest());
    endtask

    initial begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.kind            <= KIND_CLEAR;
        in_ch.register_number <= '0;
        in_ch.rec_type        <= '0;
        in_ch.num_digests     <= '0;
        in_ch.digest_word0    <= '0;
        in_ch.digest_word1    <= '0;
        in_ch.digest_word2    <= '0;
        in_ch.digest_word3    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset contents, number floor, range edges, every
        // non-extending record, end-of-log marker, unused kind, clear.
        send_word(KIND_READ, 32'd1, '0, '0, '0);
        send_word(KIND_READ, 32'd4, '0, '0, '0);
        send_word(KIND_EVENT, 32'd0, 32'd7, 32'd1, '0);
        send_word(KIND_EVENT, 32'd1, 32'd0, LOG_END_MARK, '1);
        send_word(KIND_EVENT, 32'd2, LOG_END_MARK, 32'd1, rand_digest());
        send_word(KIND_EVENT, 32'd4, 32'd1, 32'd2, rand_digest());
        send_word(KIND_EVENT, 32'd5, 32'd1, 32'd1, rand_digest());
        send_word(KIND_EVENT, 32'd3, NO_ACTION_TYPE, 32'd1, rand_digest());
        send_word(KIND_EVENT, 32'd3, 32'd1, 32'd0, rand_digest());
        send_word(KIND_EVENT, LOG_END_MARK, LOG_END_MARK, 32'd1, rand_digest());
        send_word(KIND_READ, LOG_END_MARK, '0, '0, '0);
        send_word(KIND_READ, 32'd0, '0, '0, '0);
        send_word(KIND_READ, 32'd5, '0, '0, '0);
        send_word(KIND_RSVD, 32'd1, 32'd1, 32'd1, '1);
        send_word(KIND_READ, 32'd1, '0, '0, '0);
        send_word(KIND_CLEAR, LOG_END_MARK, LOG_END_MARK, LOG_END_MARK, '1);
        send_word(KIND_READ, 32'd1, '0, '0, '0);
        send_word(KIND_EVENT, 32'd1, LOG_END_MARK, LOG_END_MARK, '1);
        send_word(KIND_READ, 32'd2, '0, '0, '0);

        // Random part in five phases: free running, sender idle,
        // receiver stalling, both, then free running again.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            case ((n * 5) / RANDOM_WORDS)
                1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin sender_idle_pct = 20; recv_stall_pct = 20; end
                default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            send_random_word();
        end
        in_ch.valid <= 1'b0;

        // Drain: every predicted word must come back, then a quiet tail
        // to catch stray extra results.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
